[hw/rtl/stl_pkg.sv]
// Shared types, character codes and classification helpers for the source tokenizer stream.
// Used by stl_front, stl_queue, stl_back and source_tokenizer_stream_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    localparam int BALANCE_BITS = 16;
    localparam int MAX_RESULTS  = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int SLOT_BITS    = $clog2(MAX_RESULTS);

    // Token kinds
    localparam logic [3:0] KIND_NUMBER   = 4'd0;
    localparam logic [3:0] KIND_DOT      = 4'd1;
    localparam logic [3:0] KIND_KEYWORD  = 4'd2;
    localparam logic [3:0] KIND_SYMBOL   = 4'd3;
    localparam logic [3:0] KIND_ASSIGN   = 4'd4;
    localparam logic [3:0] KIND_MSGKEY   = 4'd5;
    localparam logic [3:0] KIND_STRING   = 4'd6;
    localparam logic [3:0] KIND_OPERATOR = 4'd7;
    localparam logic [3:0] KIND_SEMI     = 4'd8;
    localparam logic [3:0] KIND_COMMA    = 4'd9;
    localparam logic [3:0] KIND_PAREN_L  = 4'd10;
    localparam logic [3:0] KIND_PAREN_R  = 4'd11;
    localparam logic [3:0] KIND_SQUARE_L = 4'd12;
    localparam logic [3:0] KIND_SQUARE_R = 4'd13;
    localparam logic [3:0] KIND_BRACE_L  = 4'd14;
    localparam logic [3:0] KIND_BRACE_R  = 4'd15;

    // Balance status
    localparam logic [1:0] ST_BALANCED = 2'd0;
    localparam logic [1:0] ST_PAREN    = 2'd1;
    localparam logic [1:0] ST_SQUARE   = 2'd2;
    localparam logic [1:0] ST_BRACE    = 2'd3;

    // Character codes
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_QUOTE    = 8'h27;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_PAREN_L  = 8'h28;
    localparam logic [7:0] CH_PAREN_R  = 8'h29;
    localparam logic [7:0] CH_SQUARE_L = 8'h5B;
    localparam logic [7:0] CH_SQUARE_R = 8'h5D;
    localparam logic [7:0] CH_BRACE_L  = 8'h7B;
    localparam logic [7:0] CH_BRACE_R  = 8'h7D;

    typedef struct packed {
        logic [7:0] text_char;
        logic       carries_char;
        logic       token_done;
        logic [3:0] token_kind;
        logic       source_done;
        logic [1:0] status;
    } res_t;

    // All results caused by one input item; count is never zero once queued.
    typedef struct packed {
        logic [SLOT_BITS-1:0]        count;
        res_t [MAX_RESULTS-1:0]      slot;
    } run_t;

    function automatic res_t mk_char(input logic [7:0] c);
        res_t r;
        r              = '0;
        r.text_char    = c;
        r.carries_char = 1'b1;
        return r;
    endfunction

    function automatic res_t mk_done(input logic [3:0] k);
        res_t r;
        r            = '0;
        r.token_done = 1'b1;
        r.token_kind = k;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_symchar(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_DOLLAR);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        logic hit;
        case (c)
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5C, 8'h7E, 8'h3E, 8'h3C,
            8'h3D, 8'h40, 8'h23, 8'h25, 8'h7C, 8'h26, 8'h3F, 8'h21: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/stl_front.sv]
// Front end of the tokenizer: scan mode, lookahead and bracket balances.
// Turns each accepted byte into at most one run of up to three results. Depends on stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    character,
    input  wire logic          end_of_source,
    output stl_pkg::run_t      run,
    output logic               run_valid
);
    import stl_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_MINUS, M_NUMBER, M_COLON, M_KEYWORD,
        M_SYMBOL, M_SYMCOLON, M_OPERATOR, M_STRING, M_COMMENT
    } mode_t;

    localparam logic signed [BALANCE_BITS-1:0] BAL_MAX = {1'b0, {(BALANCE_BITS-1){1'b1}}};
    localparam logic signed [BALANCE_BITS-1:0] BAL_MIN = {1'b1, {(BALANCE_BITS-1){1'b0}}};

    mode_t                          mode_reg, mode_next;
    logic                           dot_reg, dot_next;
    logic signed [BALANCE_BITS-1:0] paren_reg, paren_next;
    logic signed [BALANCE_BITS-1:0] square_reg, square_next;
    logic signed [BALANCE_BITS-1:0] brace_reg, brace_next;

    mode_t      start_mode;
    logic       start_has;
    res_t       start_res;
    logic [1:0] bump_sel;   // 0 none, 1 paren, 2 square, 3 brace
    logic       bump_up;

    logic                  do_start;
    logic [SLOT_BITS-1:0]  cnt;
    run_t                  run_w;

    function automatic logic signed [BALANCE_BITS-1:0] bump(
        input logic signed [BALANCE_BITS-1:0] v, input logic up);
        logic signed [BALANCE_BITS-1:0] r;
        r = v;
        if (up)
        begin
            if (v != BAL_MAX) r = v + 1'b1;
        end
        else
        begin
            if (v != BAL_MIN) r = v - 1'b1;
        end
        return r;
    endfunction

    // What a byte does when it opens a new token.
    always_comb
    begin
        start_mode = M_IDLE;
        start_has  = 1'b0;
        start_res  = '0;
        bump_sel   = 2'd0;
        bump_up    = 1'b0;
        if (character == CH_DQUOTE)
            start_mode = M_COMMENT;
        else if (is_digit(character))
        begin
            start_has = 1'b1; start_res = mk_char(character); start_mode = M_NUMBER;
        end
        else if (character == CH_MINUS)
            start_mode = M_MINUS;
        else if (character == CH_COLON)
            start_mode = M_COLON;
        else if (is_symchar(character))
        begin
            start_has = 1'b1; start_res = mk_char(character); start_mode = M_SYMBOL;
        end
        else if (is_op(character))
        begin
            start_has = 1'b1; start_res = mk_char(character); start_mode = M_OPERATOR;
        end
        else if (character == CH_QUOTE)
            start_mode = M_STRING;
        else
        begin
            case (character)
                CH_SEMI:     begin start_has = 1'b1; start_res = mk_done(KIND_SEMI); end
                CH_DOT:      begin start_has = 1'b1; start_res = mk_done(KIND_DOT); end
                CH_COMMA:    begin start_has = 1'b1; start_res = mk_done(KIND_COMMA); end
                CH_PAREN_L:
                begin
                    start_has = 1'b1; start_res = mk_done(KIND_PAREN_L);
                    bump_sel = 2'd1; bump_up = 1'b1;
                end
                CH_PAREN_R:
                begin
                    start_has = 1'b1; start_res = mk_done(KIND_PAREN_R); bump_sel = 2'd1;
                end
                CH_SQUARE_L:
                begin
                    start_has = 1'b1; start_res = mk_done(KIND_SQUARE_L);
                    bump_sel = 2'd2; bump_up = 1'b1;
                end
                CH_SQUARE_R:
                begin
                    start_has = 1'b1; start_res = mk_done(KIND_SQUARE_R); bump_sel = 2'd2;
                end
                CH_BRACE_L:
                begin
                    start_has = 1'b1; start_res = mk_done(KIND_BRACE_L);
                    bump_sel = 2'd3; bump_up = 1'b1;
                end
                CH_BRACE_R:
                begin
                    start_has = 1'b1; start_res = mk_done(KIND_BRACE_R); bump_sel = 2'd3;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        dot_next    = dot_reg;
        paren_next  = paren_reg;
        square_next = square_reg;
        brace_next  = brace_reg;
        do_start    = 1'b0;
        cnt         = '0;
        run_w       = '0;

        if (end_of_source)
        begin
            case (mode_reg)
                M_MINUS:
                begin
                    run_w.slot[cnt] = mk_char(CH_MINUS); cnt = cnt + 1'b1;
                    run_w.slot[cnt] = mk_done(KIND_OPERATOR); cnt = cnt + 1'b1;
                end
                M_NUMBER:
                begin
                    run_w.slot[cnt] = mk_done(KIND_NUMBER); cnt = cnt + 1'b1;
                    if (dot_reg)
                    begin
                        run_w.slot[cnt] = mk_done(KIND_DOT); cnt = cnt + 1'b1;
                    end
                end
                M_COLON, M_KEYWORD:
                begin
                    run_w.slot[cnt] = mk_done(KIND_KEYWORD); cnt = cnt + 1'b1;
                end
                M_SYMBOL:
                begin
                    run_w.slot[cnt] = mk_done(KIND_SYMBOL); cnt = cnt + 1'b1;
                end
                M_SYMCOLON:
                begin
                    run_w.slot[cnt] = mk_char(CH_COLON); cnt = cnt + 1'b1;
                    run_w.slot[cnt] = mk_done(KIND_MSGKEY); cnt = cnt + 1'b1;
                end
                M_OPERATOR:
                begin
                    run_w.slot[cnt] = mk_done(KIND_OPERATOR); cnt = cnt + 1'b1;
                end
                M_STRING:
                begin
                    run_w.slot[cnt] = mk_done(KIND_STRING); cnt = cnt + 1'b1;
                end
                default: ;
            endcase
            run_w.slot[cnt]             = '0;
            run_w.slot[cnt].source_done = 1'b1;
            if (paren_reg != '0)
                run_w.slot[cnt].status = ST_PAREN;
            else if (square_reg != '0)
                run_w.slot[cnt].status = ST_SQUARE;
            else if (brace_reg != '0)
                run_w.slot[cnt].status = ST_BRACE;
            else
                run_w.slot[cnt].status = ST_BALANCED;
            cnt = cnt + 1'b1;
            // The next source starts from a clean slate.
            mode_next   = M_IDLE;
            dot_next    = 1'b0;
            paren_next  = '0;
            square_next = '0;
            brace_next  = '0;
        end
        else
        begin
            case (mode_reg)
                M_MINUS:
                begin
                    run_w.slot[cnt] = mk_char(CH_MINUS); cnt = cnt + 1'b1;
                    if (is_digit(character))
                    begin
                        run_w.slot[cnt] = mk_char(character); cnt = cnt + 1'b1;
                        mode_next = M_NUMBER;
                    end
                    else if (is_op(character))
                    begin
                        run_w.slot[cnt] = mk_char(character); cnt = cnt + 1'b1;
                        mode_next = M_OPERATOR;
                    end
                    else
                    begin
                        run_w.slot[cnt] = mk_done(KIND_OPERATOR); cnt = cnt + 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    // A dot is held back until it is known not to end the number.
                    if (is_digit(character))
                    begin
                        if (dot_reg)
                        begin
                            run_w.slot[cnt] = mk_char(CH_DOT); cnt = cnt + 1'b1;
                        end
                        dot_next = 1'b0;
                        run_w.slot[cnt] = mk_char(character); cnt = cnt + 1'b1;
                    end
                    else if (character == CH_DOT)
                    begin
                        if (dot_reg)
                        begin
                            run_w.slot[cnt] = mk_char(CH_DOT); cnt = cnt + 1'b1;
                        end
                        dot_next = 1'b1;
                    end
                    else
                    begin
                        run_w.slot[cnt] = mk_done(KIND_NUMBER); cnt = cnt + 1'b1;
                        if (dot_reg)
                        begin
                            run_w.slot[cnt] = mk_done(KIND_DOT); cnt = cnt + 1'b1;
                        end
                        dot_next = 1'b0;
                        do_start = 1'b1;
                    end
                end
                M_COLON:
                begin
                    if (character == CH_EQUAL)
                    begin
                        run_w.slot[cnt] = mk_done(KIND_ASSIGN); cnt = cnt + 1'b1;
                        mode_next = M_IDLE;
                    end
                    else if (is_symchar(character))
                    begin
                        run_w.slot[cnt] = mk_char(character); cnt = cnt + 1'b1;
                        mode_next = M_KEYWORD;
                    end
                    else
                    begin
                        run_w.slot[cnt] = mk_done(KIND_KEYWORD); cnt = cnt + 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_KEYWORD:
                begin
                    if (is_symchar(character))
                    begin
                        run_w.slot[cnt] = mk_char(character); cnt = cnt + 1'b1;
                    end
                    else
                    begin
                        run_w.slot[cnt] = mk_done(KIND_KEYWORD); cnt = cnt + 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_SYMBOL:
                begin
                    if (is_symchar(character))
                    begin
                        run_w.slot[cnt] = mk_char(character); cnt = cnt + 1'b1;
                    end
                    else if (character == CH_COLON)
                        mode_next = M_SYMCOLON;
                    else
                    begin
                        run_w.slot[cnt] = mk_done(KIND_SYMBOL); cnt = cnt + 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_SYMCOLON:
                begin
                    if (character == CH_EQUAL)
                    begin
                        run_w.slot[cnt] = mk_done(KIND_SYMBOL); cnt = cnt + 1'b1;
                        run_w.slot[cnt] = mk_done(KIND_ASSIGN); cnt = cnt + 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        run_w.slot[cnt] = mk_char(CH_COLON); cnt = cnt + 1'b1;
                        run_w.slot[cnt] = mk_done(KIND_MSGKEY); cnt = cnt + 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_OPERATOR:
                begin
                    if (is_op(character))
                    begin
                        run_w.slot[cnt] = mk_char(character); cnt = cnt + 1'b1;
                    end
                    else
                    begin
                        run_w.slot[cnt] = mk_done(KIND_OPERATOR); cnt = cnt + 1'b1;
                        do_start = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (character == CH_QUOTE)
                    begin
                        run_w.slot[cnt] = mk_done(KIND_STRING); cnt = cnt + 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        run_w.slot[cnt] = mk_char(character); cnt = cnt + 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (character == CH_DQUOTE)
                        mode_next = M_IDLE;
                end
                default:
                    do_start = 1'b1;
            endcase

            if (do_start)
            begin
                mode_next = start_mode;
                if (start_has)
                begin
                    run_w.slot[cnt] = start_res; cnt = cnt + 1'b1;
                end
                case (bump_sel)
                    2'd1:    paren_next  = bump(paren_reg, bump_up);
                    2'd2:    square_next = bump(square_reg, bump_up);
                    2'd3:    brace_next  = bump(brace_reg, bump_up);
                    default: ;
                endcase
            end
        end
        run_w.count = cnt;
    end

    assign run       = run_w;
    assign run_valid = accept && (cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            dot_reg    <= 1'b0;
            paren_reg  <= '0;
            square_reg <= '0;
            brace_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            dot_reg    <= dot_next;
            paren_reg  <= paren_next;
            square_reg <= square_next;
            brace_reg  <= brace_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stl_queue.sv]
// Short queue of result runs between the front and back ends of the tokenizer.
// Depends on stl_pkg for the run type and depth.
`timescale 1ns / 1ps
`default_nettype none

module stl_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire stl_pkg::run_t wr_data,
    input  wire logic          rd,
    output stl_pkg::run_t      rd_data,
    output logic               full,
    output logic               empty
);
    import stl_pkg::*;

    run_t                   store [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wptr_reg;
    logic [QPTR_BITS-1:0]   rptr_reg;
    logic [QPTR_BITS:0]     fill_reg;
    logic                   do_wr;
    logic                   do_rd;

    assign full    = (fill_reg == QUEUE_DEPTH[QPTR_BITS:0]);
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = store[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= rptr_reg + 1'b1;
            if (do_wr && !do_rd)
                fill_reg <= fill_reg + 1'b1;
            else if (do_rd && !do_wr)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stl_back.sv]
// Back end of the tokenizer: holds one run and hands out its results one per transfer.
// Depends on stl_pkg; fed by stl_queue.
`timescale 1ns / 1ps
`default_nettype none

module stl_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire stl_pkg::run_t q_data,
    input  wire logic          q_empty,
    output logic               q_rd,
    input  wire logic          pop,
    output logic               empty,
    output stl_pkg::res_t      res,
    output logic               last_of_run
);
    import stl_pkg::*;

    run_t                  run_reg, run_next;
    logic [SLOT_BITS-1:0]  idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic                  advance;
    logic                  finishing;
    logic                  load;

    assign last_of_run = (idx_reg == run_reg.count - 1'b1);
    assign res         = run_reg.slot[idx_reg];
    assign empty       = !valid_reg;
    assign advance     = pop && valid_reg;
    assign finishing   = advance && last_of_run;
    // A new run is loaded, if the queue holds one, in the same cycle as the last result of the previous one goes out.
    assign load        = (!valid_reg || finishing) && !q_empty;
    assign q_rd        = load;

    always_comb
    begin
        run_next   = run_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            run_next   = q_data;
            idx_next   = '0;
            valid_next = 1'b1;
        end
        else if (finishing)
            valid_next = 1'b0;
        else if (advance)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
    end

endmodule

`default_nettype wire

[hw/rtl/source_tokenizer_stream_top.sv]
// Top level of the source tokenizer stream: front end, run queue and back end.
// Depends on stl_pkg, stl_front, stl_queue and stl_back.
`timescale 1ns / 1ps
`default_nettype none

// One source byte is taken per cycle whenever push is high and full is low;
// the front end classifies it in that cycle and writes its results (one to
// three; a byte with none writes nothing) as one run into a four-entry queue.
// Results leave one per cycle while pop is high and empty is low, so a byte
// that makes n results needs n pop transfers, and the back end's single output
// port limits the sustained rate to one result per cycle. Each run is registered
// in the queue and then in the back end before its results reach the outputs.
// full rises only when four runs wait in the queue.
module source_tokenizer_stream_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  character,
    input  wire logic        end_of_source,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       text_char,
    output logic             carries_char,
    output logic             token_done,
    output logic [3:0]       token_kind,
    output logic             source_done,
    output logic [1:0]       status,
    output logic             last_of_run
);
    import stl_pkg::*;

    logic  accept;
    run_t  f_run;
    logic  f_valid;
    run_t  q_data;
    logic  q_empty;
    logic  q_rd;
    res_t  res;

    assign accept = push && !full;

    stl_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .character     (character),
        .end_of_source (end_of_source),
        .run           (f_run),
        .run_valid     (f_valid)
    );

    stl_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_valid),
        .wr_data (f_run),
        .rd      (q_rd),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    stl_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_data),
        .q_empty     (q_empty),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .res         (res),
        .last_of_run (last_of_run)
    );

    assign text_char    = res.text_char;
    assign carries_char = res.carries_char;
    assign token_done   = res.token_done;
    assign token_kind   = res.token_kind;
    assign source_done  = res.source_done;
    assign status       = res.status;

`ifndef ASSERT_OFF
    // The end-of-source report always closes its run.
    a_sdone_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && source_done) |-> last_of_run)
        else $error("source_done result is not the last of its run");

    a_char_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(carries_char && token_done))
        else $error("result carries text and closes a token at once");

    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !source_done) |-> (status == ST_BALANCED))
        else $error("balance status reported before end of source");

    // A held result may not change while the consumer stalls.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(text_char) && $stable(token_kind)
                              && $stable(last_of_run)))
        else $error("result changed while not popped");
`endif

endmodule

`default_nettype wire
